[hdl/rpn_stack_evaluator_core_macros.svh]
// Assertion macros shared by the checker of the RPN stack evaluator.
`ifndef RPN_STACK_EVALUATOR_CORE_MACROS_SVH
`define RPN_STACK_EVALUATOR_CORE_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define RPN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hdl/rpn_pkg.sv]
// Types and constants shared by the RPN stack evaluator modules.
`default_nettype none
package rpn_pkg;
  localparam int VAL_W = 48;
  localparam logic [VAL_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 48'h8000_0000_0000;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_END  = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_BAD_OP    = 3'd4,
    ST_BAD_DEPTH = 3'd5
  } status_t;

  typedef struct packed {
    logic load_prev;
    logic load_next;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;
endpackage
`default_nettype wire

[hdl/rpn_stack_evaluator_core.sv]
// Top level of the RPN stack evaluator: stack cell row, control and result register.
// Push, add, subtract, end and every error load the result register at accept time.
// Multiply forms four 24x24 partial products, sums them and saturates; divide
// uses the restoring divider, which yields one quotient bit per cycle. One item is
// in work at a time; the next waits until its result is registered and not stalled.
// Synchronous active-low reset clears the count, error latch, FSM and valid flags.
`default_nettype none
module rpn_stack_evaluator_core #(
  parameter int STACK_DEPTH   = 128,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [47:0] in_number,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic signed [47:0]      out_top_value,
  output logic [7:0]              out_depth,
  output logic                    out_finished
);
  localparam int W  = rpn_pkg::VAL_W;
  // Count must be able to hold the full depth itself.
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  rpn_pkg::status_t  err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [W-1:0]      out_top_r, out_top_nxt;
  logic [7:0]        out_depth_r, out_depth_nxt;
  logic              out_fin_r, out_fin_nxt;

  // The stack is a row of cells: cell 0 is the top, cell 1 the one below it.
  logic [W-1:0]        cell_val [STACK_DEPTH];
  rpn_pkg::cell_ctl_t  cell_ctl [STACK_DEPTH];

  logic              out_free, in_fire;
  logic              push_do, apply_do;
  logic [W-1:0]      new_top, top_cur, x_val, y_val, addsub_res;
  logic [W:0]        sum;
  rpn_pkg::alu_req_t alu_req;
  logic              alu_done;
  logic [W-1:0]      alu_res;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign y_val   = cell_val[0];
  assign x_val   = cell_val[1];
  assign top_cur = (cnt_r != '0) ? cell_val[0] : '0;

  // Add and subtract run on a 49-bit sum and clamp to the 48-bit range.
  always_comb begin
    if (rpn_pkg::opcode_t'(in_opcode) == rpn_pkg::OP_SUB) begin
      sum = {x_val[W-1], x_val} - {y_val[W-1], y_val};
    end else begin
      sum = {x_val[W-1], x_val} + {y_val[W-1], y_val};
    end
    if (sum[W] != sum[W-1]) begin
      addsub_res = sum[W] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
    end else begin
      addsub_res = sum[W-1:0];
    end
  end

  // Token decode. Other tokens load the result register at accept time; a multiply or
  // divide that passes its checks starts the shared unit and finishes in the busy state.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_fin_nxt    = out_fin_r;
    push_do        = 1'b0;
    apply_do       = 1'b0;
    new_top        = addsub_res;
    alu_req        = '0;

    if (state_r == S_BUSY) begin
      if (alu_done && out_free) begin
        apply_do       = 1'b1;
        new_top        = alu_res;
        cnt_nxt        = cnt_r - 1'b1;
        state_nxt      = S_IDLE;
        out_valid_nxt  = 1'b1;
        out_status_nxt = rpn_pkg::ST_OK;
        out_top_nxt    = alu_res;
        out_depth_nxt  = 8'(cnt_r - 1'b1);
        out_fin_nxt    = 1'b0;
      end
    end else if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_fin_nxt   = 1'b0;
      if (rpn_pkg::opcode_t'(in_opcode) == rpn_pkg::OP_END) begin
        // End token: report the single remaining entry (or an error status with a zero value), then empty the stack.
        if (err_r != rpn_pkg::ST_OK) begin
          out_status_nxt = err_r;
          out_top_nxt    = '0;
        end else if (cnt_r != CW'(1)) begin
          out_status_nxt = rpn_pkg::ST_BAD_DEPTH;
          out_top_nxt    = '0;
        end else begin
          out_status_nxt = rpn_pkg::ST_OK;
          out_top_nxt    = cell_val[0];
        end
        cnt_nxt       = '0;
        err_nxt       = rpn_pkg::ST_OK;
        out_depth_nxt = 8'd0;
        out_fin_nxt   = 1'b1;
      end else begin
        if (err_r == rpn_pkg::ST_OK) begin
          unique case (rpn_pkg::opcode_t'(in_opcode))
            rpn_pkg::OP_PUSH: begin
              if (cnt_r >= CW'(STACK_DEPTH)) begin
                err_nxt = rpn_pkg::ST_FULL;
              end else begin
                push_do = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
              if (cnt_r < CW'(2)) begin
                err_nxt = rpn_pkg::ST_EMPTY;
              end else begin
                apply_do = 1'b1;
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
              if (cnt_r < CW'(2)) begin
                err_nxt = rpn_pkg::ST_EMPTY;
              end else if ((rpn_pkg::opcode_t'(in_opcode) == rpn_pkg::OP_DIV) &&
                           (y_val == '0)) begin
                err_nxt = rpn_pkg::ST_DIV_ZERO;
              end else begin
                alu_req.start = 1'b1;
                alu_req.div   = (rpn_pkg::opcode_t'(in_opcode) == rpn_pkg::OP_DIV);
                state_nxt     = S_BUSY;
                out_valid_nxt = 1'b0;
              end
            end
            default: begin
              err_nxt = rpn_pkg::ST_BAD_OP;
            end
          endcase
        end
        out_status_nxt = err_nxt;
        out_depth_nxt  = 8'(cnt_nxt);
        if (push_do) begin
          out_top_nxt = in_number;
        end else if (apply_do) begin
          out_top_nxt = addsub_res;
        end else begin
          out_top_nxt = top_cur;
        end
      end
    end
    if (push_do) begin
      new_top = in_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= rpn_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_fin_r    <= out_fin_nxt;
  end

  // A push moves every entry one cell down; an applied result lands in the top
  // cell while the rest move one cell up to close the popped slot.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0] prev_v, next_v;
    if (i == 0) begin : g_top
      assign prev_v = new_top;
    end else begin : g_mid
      assign prev_v = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_v = cell_val[i];
    end else begin : g_inner
      assign next_v = cell_val[i+1];
    end
    assign cell_ctl[i].load_prev = push_do || (apply_do && (i == 0));
    assign cell_ctl[i].load_next = apply_do && (i != 0);
    rpn_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_val[i])
    );
  end

  rpn_muldiv #(.FRACTION_BITS(FRACTION_BITS)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (x_val),
    .b     (y_val),
    .done  (alu_done),
    .res   (alu_res)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_finished  = out_fin_r;
endmodule
`default_nettype wire

[hdl/rpn_cell.sv]
// One stack entry; takes the value of either neighbor when the stack moves.
`default_nettype none
module rpn_cell (
  input  wire logic                           clk,
  input  wire rpn_pkg::cell_ctl_t             ctl,
  input  wire logic [rpn_pkg::VAL_W-1:0]      prev_val,
  input  wire logic [rpn_pkg::VAL_W-1:0]      next_val,
  output logic      [rpn_pkg::VAL_W-1:0]      val
);
  logic [rpn_pkg::VAL_W-1:0] val_r;

  always_ff @(posedge clk) begin
    priority if (ctl.load_prev) begin
      val_r <= prev_val;
    end else if (ctl.load_next) begin
      val_r <= next_val;
    end else begin
      val_r <= val_r;
    end
  end

  assign val = val_r;
endmodule
`default_nettype wire

[hdl/rpn_muldiv.sv]
// Sequential fixed-point multiply and restoring divide with saturation.
`default_nettype none
module rpn_muldiv #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rpn_pkg::alu_req_t            req,
  input  wire logic [rpn_pkg::VAL_W-1:0]    a,
  input  wire logic [rpn_pkg::VAL_W-1:0]    b,
  output logic                              done,
  output logic      [rpn_pkg::VAL_W-1:0]    res
);
  localparam int W    = rpn_pkg::VAL_W;
  localparam int DN   = W + FRACTION_BITS;
  localparam int CNTW = $clog2(DN + 1);
  localparam int HW   = W / 2;
  localparam logic [2*W-1:0] MAG_MAX = {{W{1'b0}}, rpn_pkg::VAL_MAX};
  localparam logic [2*W-1:0] MAG_MIN = {{W{1'b0}}, rpn_pkg::VAL_MIN};

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_FIN, A_DONE} astate_t;

  astate_t          state_r;
  logic [W-1:0]     ma_r, mb_r, q_r, rem_r, res_r;
  logic             neg_r, div_r, ovf_r;
  logic [2*W-1:0]   acc_r;
  logic [W-1:0]     pp_r;
  logic [2:0]       step_r;
  logic [1:0]       sh_r;
  logic [DN-1:0]    dv_r;
  logic [CNTW-1:0]  cnt_r;

  logic [W-1:0]     ma_in, mb_in;
  logic [HW-1:0]    half_a, half_b;
  logic [2*W-1:0]   pp_shift;
  logic [W:0]       trial;
  logic             ge;
  logic [2*W-1:0]   mag;
  logic [W-1:0]     sat;

  always_comb begin
    ma_in  = a[W-1] ? W'(-a) : a;
    mb_in  = b[W-1] ? W'(-b) : b;
    half_a = step_r[1] ? ma_r[W-1:HW] : ma_r[HW-1:0];
    half_b = step_r[0] ? mb_r[W-1:HW] : mb_r[HW-1:0];
    unique case (sh_r)
      2'd0:    pp_shift = {{W{1'b0}}, pp_r};
      2'd1:    pp_shift = {{W{1'b0}}, pp_r} << HW;
      default: pp_shift = {{W{1'b0}}, pp_r} << (2 * HW);
    endcase
    trial = {rem_r, dv_r[DN-1]};
    ge    = trial >= {1'b0, mb_r};
    if (div_r) begin
      mag = ovf_r ? {(2*W){1'b1}} : {{W{1'b0}}, q_r};
    end else begin
      mag = acc_r >> FRACTION_BITS;
    end
    if (neg_r) begin
      sat = (mag > MAG_MIN) ? rpn_pkg::VAL_MIN : W'(-mag[W-1:0]);
    end else begin
      sat = (mag > MAG_MAX) ? rpn_pkg::VAL_MAX : mag[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      if (req.start) begin
        ma_r   <= ma_in;
        mb_r   <= mb_in;
        neg_r  <= a[W-1] ^ b[W-1];
        div_r  <= req.div;
        acc_r  <= '0;
        step_r <= '0;
        dv_r   <= DN'(ma_in) << FRACTION_BITS;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= '0;
        state_r <= req.div ? A_DIV : A_MUL;
      end else begin
        unique case (state_r)
          A_MUL: begin
            if (step_r != 3'd4) begin
              pp_r <= half_a * half_b;
              sh_r <= 2'(step_r[1]) + 2'(step_r[0]);
            end
            if (step_r != 3'd0) begin
              acc_r <= acc_r + pp_shift;
            end
            step_r <= step_r + 3'd1;
            if (step_r == 3'd4) begin
              state_r <= A_FIN;
            end
          end
          A_DIV: begin
            rem_r <= ge ? W'(trial - {1'b0, mb_r}) : trial[W-1:0];
            q_r   <= {q_r[W-2:0], ge};
            ovf_r <= ovf_r | q_r[W-1];
            dv_r  <= dv_r << 1;
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == CNTW'(DN - 1)) begin
              state_r <= A_FIN;
            end
          end
          A_FIN: begin
            res_r   <= sat;
            state_r <= A_DONE;
          end
          default: begin
            state_r <= state_r;
          end
        endcase
      end
    end
  end

  assign done = (state_r == A_DONE);
  assign res  = res_r;
endmodule
`default_nettype wire

[hdl/rpn_checker.sv]
// Port-level assertions for the RPN stack evaluator and their bind.
`default_nettype none
`include "rpn_stack_evaluator_core_macros.svh"
module rpn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [47:0] out_top_value,
  input wire logic [7:0]  out_depth,
  input wire logic        out_finished
);
  logic fin_err;
  logic fin_out;

  assign fin_out = out_valid && out_finished;
  assign fin_err = fin_out && (out_status != rpn_pkg::ST_OK);

  `RPN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `RPN_ASSERT_NOW(a_fin_empty, fin_out, out_depth == 8'd0, "end left entries")
  `RPN_ASSERT_NOW(a_fin_err_zero, fin_err, out_top_value == 48'd0, "failed end reports value")
  `RPN_ASSERT_NOW(a_status_range, out_valid, out_status <= rpn_pkg::ST_BAD_DEPTH, "unknown status")
endmodule

bind rpn_stack_evaluator_core rpn_checker u_rpn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_top_value (out_top_value),
  .out_depth     (out_depth),
  .out_finished  (out_finished)
);
`default_nettype wire
